### rtl/core/kmdg_pkg.sv
// Shared constants and types for the key matrix debounce and ghost detect block.
package kmdg_pkg;

    localparam int ROWS = 8;
    localparam int COLS = 18;

    localparam int ROW_IDX_W = 3;
    localparam int COL_W     = 18;
    localparam int CNT_W     = 8;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CNT_W-1:0]  DEBOUNCE_RESET = CNT_W'(5);
    localparam logic [APB_AW-1:0] ADDR_DEBOUNCE  = APB_AW'(0);

    typedef logic [COLS-1:0] row_bits_t;

    typedef struct packed {
        logic [COL_W-1:0] stable_row;
        logic             row_ghost;
        logic             committed;
        logic             settling;
    } result_t;

endpackage

### rtl/core/kmdg_core.sv
// Pending and stable key matrix, settle counter and per-item result logic.
module kmdg_core
    import kmdg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [ROW_IDX_W-1:0] row_index,
    input  logic [COL_W-1:0]     column_bits,
    input  logic                 end_of_scan,
    input  logic [CNT_W-1:0]     debounce_scans,
    output result_t              result
);

    row_bits_t        pending_reg [ROWS];
    row_bits_t        pending_next [ROWS];
    row_bits_t        stable_reg [ROWS];
    row_bits_t        stable_next [ROWS];
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    logic [ROWS-1:0]  hit;
    logic [ROWS-1:0]  ghost;
    row_bits_t        cols;
    row_bits_t        pend_sel;
    row_bits_t        stab_sel;
    logic             changed;
    logic [CNT_W-1:0] reload;
    logic [CNT_W-1:0] cnt_mid;
    logic             commit;

    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            hit[i] = (32'(row_index) == i);
        end
        // drop column lines beyond the matrix width
        for (int c = 0; c < COLS; c++)
        begin
            cols[c] = (c < COL_W) ? column_bits[c % COL_W] : 1'b0;
        end
    end

    always_comb
    begin
        pend_sel = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            pend_sel = pend_sel | (pending_reg[i] & {COLS{hit[i]}});
        end
        changed = (|hit) && (pend_sel != cols);
        reload  = (debounce_scans == '0) ? CNT_W'(1) : debounce_scans;
        cnt_mid = changed ? reload : cnt_reg;
        commit  = end_of_scan && (cnt_mid != '0) && (cnt_mid == CNT_W'(1));
        cnt_next = (end_of_scan && (cnt_mid != '0)) ? cnt_mid - CNT_W'(1) : cnt_mid;

        for (int i = 0; i < ROWS; i++)
        begin
            pending_next[i] = (hit[i] && changed) ? cols : pending_reg[i];
        end
        for (int i = 0; i < ROWS; i++)
        begin
            stable_next[i] = commit ? pending_next[i] : stable_reg[i];
        end
    end

    // ghost check on the stable matrix as it stands after this item
    always_comb
    begin
        row_bits_t others;
        for (int i = 0; i < ROWS; i++)
        begin
            others = '0;
            for (int j = 0; j < ROWS; j++)
            begin
                if (j != i)
                begin
                    others = others | stable_next[j];
                end
            end
            ghost[i] = (((stable_next[i] - COLS'(1)) & stable_next[i]) != '0)
                       && ((others & stable_next[i]) != '0);
        end
    end

    always_comb
    begin
        stab_sel = '0;
        for (int i = 0; i < ROWS; i++)
        begin
            stab_sel = stab_sel | (stable_next[i] & {COLS{hit[i]}});
        end
        for (int c = 0; c < COL_W; c++)
        begin
            result.stable_row[c] = (c < COLS) ? stab_sel[c % COLS] : 1'b0;
        end
        result.row_ghost = |(ghost & hit);
        result.committed = commit;
        result.settling  = (cnt_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                pending_reg[i] <= '0;
                stable_reg[i]  <= '0;
            end
            cnt_reg <= DEBOUNCE_RESET;
        end
        else if (accept)
        begin
            for (int i = 0; i < ROWS; i++)
            begin
                pending_reg[i] <= pending_next[i];
                stable_reg[i]  <= stable_next[i];
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/core/kmdg_out_buf.sv
// Result register with a skid stage so an item is taken while a result waits.
module kmdg_out_buf
    import kmdg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    main_valid_next;
    result_t main_reg;
    result_t main_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_reg;
    result_t skid_next;
    logic    pop;

    assign pop       = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (!main_valid_reg)
        begin
            main_valid_next = push;
            main_next       = push_data;
        end
        else if (push)
        begin
            // park the item behind the waiting result
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

### rtl/core/key_matrix_debounce_ghost.sv
// Top level: configuration port, debounce core and result buffer.
//
// Scanned key matrix debouncer with ghost detection. Each item is one row's column
// sample; one result comes back per item, registered in the result buffer when the item
// is accepted, and a new item is taken every cycle while in_stall is low. The pending and
// stable matrices live in flip-flops and all row compares and the ghost check run in
// parallel in the single update stage; a two-entry result buffer keeps input flowing for
// one extra item while the result side stalls. The debounce_scans register sits at APB
// address 0 (reset 5); write it only while the block is idle.
module key_matrix_debounce_ghost
    import kmdg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [ROW_IDX_W-1:0] row_index,
    input  logic [COL_W-1:0]     column_bits,
    input  logic                 end_of_scan,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COL_W-1:0]     stable_row,
    output logic                 row_ghost,
    output logic                 committed,
    output logic                 settling
);

    logic [CNT_W-1:0] debounce_reg;
    logic             accept;
    logic             buf_full;
    result_t          core_result;
    result_t          out_data;

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_DEBOUNCE) ? APB_DW'(debounce_reg) : '0;
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_DEBOUNCE))
        begin
            debounce_reg <= pwdata[CNT_W-1:0];
        end
    end

    kmdg_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .row_index      (row_index),
        .column_bits    (column_bits),
        .end_of_scan    (end_of_scan),
        .debounce_scans (debounce_reg),
        .result         (core_result)
    );

    kmdg_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign stable_row = out_data.stable_row;
    assign row_ghost  = out_data.row_ghost;
    assign committed  = out_data.committed;
    assign settling   = out_data.settling;

endmodule

### test/tb_top.sv
// Self-checking testbench for the key matrix debounce and ghost detect block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kmdg_pkg::*;

    class matrix_scoreboard;
        row_bits_t        pending_rows [ROWS];
        row_bits_t        stable_rows [ROWS];
        logic [CNT_W-1:0] settle_count;
        logic [CNT_W-1:0] debounce_scans;
        result_t          expected_reports [$];
        int unsigned      checked;

        function new();
            for (int i = 0; i < ROWS; i++)
            begin
                pending_rows[i] = '0;
                stable_rows[i]  = '0;
            end
            debounce_scans = DEBOUNCE_RESET;
            settle_count   = DEBOUNCE_RESET;
            checked        = 0;
        endfunction

        function void set_debounce(logic [CNT_W-1:0] value);
            debounce_scans = value;
        endfunction

        function int depth();
            return expected_reports.size();
        endfunction

        function bit row_ghosted(int unsigned r);
            row_bits_t bits;
            bits = stable_rows[r];
            if ($countones(bits) < 2)
                return 1'b0;
            for (int i = 0; i < ROWS; i++)
            begin
                if (i != r && (stable_rows[i] & bits) != '0)
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_item(logic [ROW_IDX_W-1:0] row, row_bits_t cols, logic eos);
            result_t want;
            want.committed = 1'b0;
            if (pending_rows[row] != cols)
            begin
                pending_rows[row] = cols;
                settle_count = (debounce_scans == '0) ? CNT_W'(1) : debounce_scans;
            end
            // sample is stored first, then the end of scan counts
            if (eos && settle_count != '0)
            begin
                settle_count = settle_count - 1'b1;
                if (settle_count == '0)
                begin
                    for (int i = 0; i < ROWS; i++)
                        stable_rows[i] = pending_rows[i];
                    want.committed = 1'b1;
                end
            end
            want.stable_row = stable_rows[row];
            want.row_ghost  = row_ghosted(row);
            want.settling   = (settle_count != '0);
            expected_reports.push_back(want);
        endfunction

        function bit check_result(result_t got, output string msg);
            result_t want;
            msg = "";
            if (expected_reports.size() == 0)
            begin
                msg = $sformatf("result with no item pending: row %h ghost %b commit %b settle %b",
                                got.stable_row, got.row_ghost, got.committed, got.settling);
                return 1'b0;
            end
            want = expected_reports.pop_front();
            checked++;
            if (got !== want)
            begin
                msg = $sformatf(
                    "result %0d: row %h/%h ghost %b/%b commit %b/%b settle %b/%b (got/exp)",
                    checked, got.stable_row, want.stable_row, got.row_ghost, want.row_ghost,
                    got.committed, want.committed, got.settling, want.settling);
                return 1'b0;
            end
            return 1'b1;
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 in_valid;
    logic                 in_stall;
    logic [ROW_IDX_W-1:0] row_index;
    logic [COL_W-1:0]     column_bits;
    logic                 end_of_scan;
    logic                 out_valid;
    logic                 out_stall;
    logic [COL_W-1:0]     stable_row;
    logic                 row_ghost;
    logic                 committed;
    logic                 settling;

    matrix_scoreboard sb = new();
    int unsigned      mismatches = 0;
    bit               hold_req = 1'b0;
    bit               no_gaps = 1'b0;

    key_matrix_debounce_ghost uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .row_index   (row_index),
        .column_bits (column_bits),
        .end_of_scan (end_of_scan),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .stable_row  (stable_row),
        .row_ghost   (row_ghost),
        .committed   (committed),
        .settling    (settling)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        mismatches++;
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 60)
            return 0;
        else if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_item(input logic [ROW_IDX_W-1:0] row, input row_bits_t cols,
                             input logic eos);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    = 1'b1;
        row_index   = row;
        column_bits = cols;
        end_of_scan = eos;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(row, cols, eos);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.depth() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [APB_DW-1:0] data);
        logic [APB_DW-1:0] readback;
        drain_results();
        repeat (4) @(posedge clk);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_DEBOUNCE;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_debounce(data[CNT_W-1:0]);
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        if (readback[CNT_W-1:0] !== sb.debounce_scans)
            report_mismatch($sformatf("debounce_scans read %h, wrote %h",
                                      readback[CNT_W-1:0], sb.debounce_scans));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    function automatic row_bits_t pick_columns();
        int        k;
        row_bits_t v;
        k = $urandom_range(0, 9);
        v = '0;
        if (k < 3)
            v = '0;
        else if (k < 5)
            v[$urandom_range(0, 5)] = 1'b1;
        else if (k < 6)
            v[$urandom_range(0, COLS - 1)] = 1'b1;
        else if (k < 8)
        begin
            // crowd a few columns so rows overlap and ghost
            v[$urandom_range(0, 5)] = 1'b1;
            v[$urandom_range(0, 5)] = 1'b1;
            v[$urandom_range(0, 7)] = 1'b1;
        end
        else
            v = row_bits_t'($urandom());
        return v;
    endfunction

    task automatic run_scan_burst(output int sent);
        row_bits_t target [ROWS];
        row_bits_t sample;
        int        reps;
        sent = 0;
        for (int r = 0; r < ROWS; r++)
            target[r] = pick_columns();
        reps = $urandom_range(1, 6);
        no_gaps = ($urandom_range(0, 1) == 0);
        for (int s = 0; s < reps; s++)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                sample = target[r];
                // bounce on the first scan
                if (s == 0 && $urandom_range(0, 3) == 0)
                    sample[$urandom_range(0, COLS - 1)] ^= 1'b1;
                send_item(ROW_IDX_W'(r), sample, r == ROWS - 1);
                sent++;
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic run_random(input int count, input bit pause_mid);
        int n;
        int sent;
        bit paused;
        n = 0;
        paused = 1'b0;
        while (n < count)
        begin
            if (pause_mid && !paused && n >= count / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                run_scan_burst(sent);
                n += sent;
            end
            else
            begin
                send_item(ROW_IDX_W'($urandom_range(0, ROWS - 1)), row_bits_t'($urandom()),
                          $urandom_range(0, 3) == 0);
                n++;
            end
        end
    endtask

    // receiver side: random stalls, plus one long hold when asked
    initial
    begin
        int run;
        int stall;
        int k;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (79) @(negedge clk);
                hold_req = 1'b0;
            end
            k = $urandom_range(0, 9);
            run = (k < 2) ? $urandom_range(30, 60) : $urandom_range(1, 12);
            k = $urandom_range(0, 9);
            stall = (k < 5) ? $urandom_range(1, 2) :
                    (k < 9) ? $urandom_range(3, 6) : $urandom_range(10, 30);
            @(negedge clk);
            out_stall = 1'b0;
            repeat (run - 1) @(negedge clk);
            @(negedge clk);
            out_stall = 1'b1;
            repeat (stall - 1) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        string   msg;
        if (rst_n && out_valid && !out_stall)
        begin
            got.stable_row = stable_row;
            got.row_ghost  = row_ghost;
            got.committed  = committed;
            got.settling   = settling;
            if (!sb.check_result(got, msg))
                report_mismatch(msg);
        end
    end

    initial
    begin
        logic [APB_DW-1:0] settings [6];
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        row_index   = '0;
        column_bits = '0;
        end_of_scan = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // counter starts at its reset value: fifth end of scan commits zeros
        for (int i = 0; i < 5; i++)
            send_item(ROW_IDX_W'(i), '0, 1'b1);
        send_item('0, '1, 1'b0);
        // change on the last row reloads, then counts this scan
        send_item(ROW_IDX_W'(ROWS - 1), '1, 1'b1);
        for (int i = 1; i <= 4; i++)
            send_item(ROW_IDX_W'(i), '0, 1'b1);
        send_item('0, '1, 1'b0);
        send_item(ROW_IDX_W'(ROWS - 1), '1, 1'b0);

        // low byte zero: reload acts as one scan
        cfg_write(32'hFFFF_FF00);
        send_item(ROW_IDX_W'(5), 18'h20001, 1'b1);
        send_item(ROW_IDX_W'(5), 18'h20001, 1'b0);
        send_item(ROW_IDX_W'(2), 18'h00001, 1'b0);
        send_item(ROW_IDX_W'(6), 18'h00003, 1'b1);
        send_item('0, '0, 1'b1);
        send_item(ROW_IDX_W'(6), 18'h00003, 1'b0);
        send_item(ROW_IDX_W'(3), 18'h2AAAA, 1'b0);
        send_item(ROW_IDX_W'(4), 18'h15555, 1'b1);

        settings = '{32'd1, 32'd255, 32'd2, 32'd3, 32'd4, 32'd0};
        settings[5] = $urandom_range(1, 8);
        for (int p = 0; p < 6; p++)
        begin
            cfg_write(settings[p]);
            if (p == 1)
                hold_req = 1'b1;
            run_random(55, p == 2);
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/kmdg_pkg.sv
rtl/core/kmdg_core.sv
rtl/core/kmdg_out_buf.sv
rtl/core/key_matrix_debounce_ghost.sv
test/tb_top.sv
